@@ design/sls_pkg.sv @@
// ----------------------------------------------------------------------------
// sls_pkg
// Shared types and constants of the sparse linear scorer.
// ----------------------------------------------------------------------------
package sls_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int MAX_PROBES_DEF    = 8;
    localparam int KEY_W   = 64;
    localparam int VAL_W   = 32;
    localparam int SCORE_W = 48;

    localparam logic OP_ADD_WEIGHT = 1'b0;
    localparam logic OP_TERM       = 1'b1;

    localparam logic KIND_ACK   = 1'b0;
    localparam logic KIND_SCORE = 1'b1;

    // Command passed from the front end to the back end through the queue.
    typedef struct packed {
        logic              opcode;
        logic [KEY_W-1:0]  feature_key;
        logic [VAL_W-1:0]  item_value;
        logic              last_term;
    } cmd_t;

endpackage

@@ design/sls_front.sv @@
// ----------------------------------------------------------------------------
// sls_front
// Accepts decoded items from the input stream and holds them in a
// short queue for the back end.
// ----------------------------------------------------------------------------
module sls_front
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  sls_pkg::cmd_t in_cmd,
    output logic         q_valid,
    input  logic         q_pop,
    output sls_pkg::cmd_t q_cmd
);
    import sls_pkg::*;

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_cmd    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_cmd;
    end

endmodule

@@ design/sls_back.sv @@
// ----------------------------------------------------------------------------
// sls_back
// Probes the hashed weight table, updates weights or accumulates products,
// and drives the result register.
// ----------------------------------------------------------------------------
module sls_back
#(
    parameter int TABLE_ENTRIES = sls_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_PROBES    = sls_pkg::MAX_PROBES_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    output logic                           q_pop,
    input  sls_pkg::cmd_t                  q_cmd,
    input  logic signed [sls_pkg::VAL_W-1:0] threshold,
    output logic                           res_valid,
    input  logic                           res_ready,
    output logic                           res_kind,
    output logic                           res_full,
    output logic [sls_pkg::SCORE_W-1:0]    res_score,
    output logic                           res_label
);
    import sls_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int PW = $clog2(MAX_PROBES + 1);
    localparam logic [AW:0] LAST_SLOT = (AW+1)'(TABLE_ENTRIES - 1);
    localparam logic signed [SCORE_W:0] S48_MAX = {2'b00, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W:0] S48_MIN = {2'b11, {(SCORE_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_HASH, ST_READ, ST_CHECK, ST_MUL, ST_ACC, ST_SCORE
    } state_t;

    // Key and weight tables and their valid bits.
    logic [KEY_W-1:0] key_mem  [TABLE_ENTRIES];
    logic [VAL_W-1:0] wgt_mem  [TABLE_ENTRIES];
    logic             valid_mem [TABLE_ENTRIES];

    state_t           state_reg;
    cmd_t             cmd_reg;
    logic [AW-1:0]    slot_reg;
    logic [PW-1:0]    probe_reg;
    logic [KEY_W-1:0] rd_key_reg;
    logic [VAL_W-1:0] rd_wgt_reg;
    logic             rd_valid_reg;
    logic signed [2*VAL_W-1:0]  prod_reg;
    logic signed [SCORE_W-1:0]  acc_reg;
    logic             res_valid_reg;
    logic             res_kind_reg;
    logic             res_full_reg;
    logic [SCORE_W-1:0] res_score_reg;
    logic             res_label_reg;
    logic             wr_en;
    logic [KEY_W-1:0] wr_key;
    logic [VAL_W-1:0] wr_wgt;
    logic             valid_we;
    logic             valid_wdata;
    logic [AW-1:0]    slot_next;
    logic [AW-1:0]    home_slot;
    logic signed [VAL_W:0]   wsum;
    logic [VAL_W-1:0]        wsat;
    logic signed [SCORE_W:0] acc_sum;
    logic signed [SCORE_W:0] sc_diff;

    assign q_pop     = (state_reg == ST_IDLE) && q_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res_kind  = res_kind_reg;
    assign res_full  = res_full_reg;
    assign res_score = res_score_reg;
    assign res_label = res_label_reg;

    // Home slot: the low key bits, as the table size is a power of two.
    assign home_slot = cmd_reg.feature_key[AW-1:0];
    assign slot_next = ({1'b0, slot_reg} == LAST_SLOT) ? '0 : slot_reg + 1'b1;

    always_comb
    begin
        wsum = $signed({rd_wgt_reg[VAL_W-1], rd_wgt_reg})
             + $signed({cmd_reg.item_value[VAL_W-1], cmd_reg.item_value});
        if (wsum[VAL_W] != wsum[VAL_W-1])
            wsat = wsum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        else
            wsat = wsum[VAL_W-1:0];
        // Arithmetic shift floors the Q32.32 product to Q32.16.
        acc_sum = $signed({acc_reg[SCORE_W-1], acc_reg})
                + $signed(prod_reg[2*VAL_W-1:16]);
        sc_diff = $signed({acc_reg[SCORE_W-1], acc_reg})
                - $signed({{(SCORE_W-VAL_W+1){threshold[VAL_W-1]}}, threshold});
    end

    always_ff @(posedge clk)
    begin
        rd_key_reg   <= key_mem[slot_reg];
        rd_wgt_reg   <= wgt_mem[slot_reg];
        rd_valid_reg <= valid_mem[slot_reg];
        if (wr_en)
        begin
            key_mem[slot_reg] <= wr_key;
            wgt_mem[slot_reg] <= wr_wgt;
        end
        if (valid_we)
            valid_mem[slot_reg] <= valid_wdata;
    end

    always_comb
    begin
        wr_en  = 1'b0;
        wr_key = cmd_reg.feature_key;
        wr_wgt = cmd_reg.item_value;
        if (state_reg == ST_CHECK && cmd_reg.opcode == OP_ADD_WEIGHT)
        begin
            if (!rd_valid_reg)
                wr_en = 1'b1;
            else if (rd_key_reg == cmd_reg.feature_key)
            begin
                wr_en  = 1'b1;
                wr_wgt = wsat;
            end
        end
        // The clearing pass after reset marks every slot empty.
        valid_we    = wr_en || (state_reg == ST_CLEAR);
        valid_wdata = (state_reg != ST_CLEAR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            acc_reg       <= '0;
            res_valid_reg <= 1'b0;
            probe_reg     <= '0;
            slot_reg      <= '0;
        end
        else
        begin
            if (res_valid_reg && res_ready)
                res_valid_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR:
                begin
                    slot_reg <= slot_next;
                    if ({1'b0, slot_reg} == LAST_SLOT)
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (q_pop)
                    begin
                        cmd_reg   <= q_cmd;
                        probe_reg <= '0;
                        state_reg <= ST_HASH;
                    end
                end
                ST_HASH:
                begin
                    slot_reg  <= home_slot;
                    state_reg <= ST_READ;
                end
                ST_READ:
                begin
                    state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    if (!rd_valid_reg || rd_key_reg == cmd_reg.feature_key)
                    begin
                        if (cmd_reg.opcode == OP_ADD_WEIGHT)
                        begin
                            res_valid_reg <= 1'b1;
                            res_kind_reg  <= KIND_ACK;
                            res_full_reg  <= 1'b0;
                            res_score_reg <= '0;
                            res_label_reg <= 1'b0;
                            state_reg     <= ST_IDLE;
                        end
                        else if (rd_valid_reg)
                            state_reg <= ST_MUL;
                        else
                            state_reg <= ST_SCORE;
                    end
                    else if (probe_reg == PW'(MAX_PROBES - 1))
                    begin
                        if (cmd_reg.opcode == OP_ADD_WEIGHT)
                        begin
                            res_valid_reg <= 1'b1;
                            res_kind_reg  <= KIND_ACK;
                            res_full_reg  <= 1'b1;
                            res_score_reg <= '0;
                            res_label_reg <= 1'b0;
                            state_reg     <= ST_IDLE;
                        end
                        else
                            state_reg <= ST_SCORE;
                    end
                    else
                    begin
                        probe_reg <= probe_reg + 1'b1;
                        slot_reg  <= slot_next;
                        state_reg <= ST_READ;
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= $signed(cmd_reg.item_value) * $signed(rd_wgt_reg);
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (acc_sum > S48_MAX)
                        acc_reg <= S48_MAX[SCORE_W-1:0];
                    else if (acc_sum < S48_MIN)
                        acc_reg <= S48_MIN[SCORE_W-1:0];
                    else
                        acc_reg <= acc_sum[SCORE_W-1:0];
                    state_reg <= ST_SCORE;
                end
                ST_SCORE:
                begin
                    if (cmd_reg.last_term)
                    begin
                        res_valid_reg <= 1'b1;
                        res_kind_reg  <= KIND_SCORE;
                        res_full_reg  <= 1'b0;
                        if (sc_diff > S48_MAX)
                            res_score_reg <= S48_MAX[SCORE_W-1:0];
                        else if (sc_diff < S48_MIN)
                            res_score_reg <= S48_MIN[SCORE_W-1:0];
                        else
                            res_score_reg <= sc_diff[SCORE_W-1:0];
                        res_label_reg <= (sc_diff > 0);
                        acc_reg       <= '0;
                    end
                    state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ design/sparse_linear_score.sv @@
// ----------------------------------------------------------------------------
// sparse_linear_score
// Hashed sparse linear scorer with weight load and feature-term scoring.
// ----------------------------------------------------------------------------
// After reset the back end clears the valid bits of every table slot before it
// takes the first item; TABLE_ENTRIES must be a power of two, since the home
// slot is the low key bits. After the item is taken and its home slot formed,
// each linear probe step is a registered table read plus a compare. A weight
// add ends with its last compare. A feature term then goes through the score
// step, with the multiply and the accumulate before it when its key is present.
// A two-entry queue lets the input keep accepting while the back end works; a
// result register holds one finished result and the back end takes no new item
// until that result is taken, at the latest in the cycle it is taken.
module sparse_linear_score
#(
    parameter int TABLE_ENTRIES = sls_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_PROBES    = sls_pkg::MAX_PROBES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,  // feature_key[63:0], item_value[95:64], zero pad
    input  logic         s_axis_tlast,  // last_term
    input  logic         s_axis_tuser,  // opcode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [55:0]  m_axis_tdata,  // table_full[0], score[48:1], label_positive[49], pad
    output logic         m_axis_tuser,  // result_kind
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata      // score_threshold
);
    import sls_pkg::*;

    cmd_t in_cmd;
    cmd_t q_cmd;
    logic q_valid;
    logic q_pop;
    logic signed [VAL_W-1:0] threshold_reg;
    logic res_full;
    logic [SCORE_W-1:0] res_score;
    logic res_label;

    assign in_cmd.opcode      = s_axis_tuser;
    assign in_cmd.feature_key = s_axis_tdata[63:0];
    assign in_cmd.item_value  = s_axis_tdata[95:64];
    assign in_cmd.last_term   = s_axis_tlast;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            threshold_reg <= '0;
        else if (cfg_we)
            threshold_reg <= cfg_wdata;
    end

    sls_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (in_cmd),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_cmd    (q_cmd)
    );

    sls_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_PROBES    (MAX_PROBES)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd),
        .threshold (threshold_reg),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res_kind  (m_axis_tuser),
        .res_full  (res_full),
        .res_score (res_score),
        .res_label (res_label)
    );

    assign m_axis_tdata = {6'd0, res_label, res_score, res_full};

endmodule

@@ verif/sls_checker.sv @@
// ----------------------------------------------------------------------------
// sls_checker
// Watches both streams of the sparse linear scorer, predicts each result
// from its own copy of the weight table and accumulator, and counts
// mismatches.
// ----------------------------------------------------------------------------
module sls_checker
    import sls_pkg::*;
#(
    parameter int ENTRIES = TABLE_ENTRIES_DEF,
    parameter int PROBES  = MAX_PROBES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    input  logic         s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [55:0]  m_axis_tdata,
    input  logic         m_axis_tuser,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,
    output int           errors,
    output int           pending
);

    typedef struct packed {
        logic               kind;
        logic               full;
        logic [SCORE_W-1:0] score;
        logic               label;
    } score_result_t;

    localparam longint S48_MAX = 64'sh7FFF_FFFF_FFFF;
    localparam longint S48_MIN = -64'sh8000_0000_0000;

    logic [KEY_W-1:0] keys [ENTRIES];
    int               weights [ENTRIES];
    bit               used [ENTRIES];
    longint           acc;
    longint           threshold;
    score_result_t    expected_q[$];

    assign pending = expected_q.size();

    function automatic longint clamp48(longint v);
        if (v > S48_MAX) return S48_MAX;
        if (v < S48_MIN) return S48_MIN;
        return v;
    endfunction

    // Walks the probe chain; returns hit slot or -1, free slot in free_idx.
    function automatic int find_slot(logic [KEY_W-1:0] key, output int free_idx);
        int slot;
        slot = int'(key % ENTRIES);
        free_idx = -1;
        for (int p = 0; p < PROBES; p++)
        begin
            if (!used[slot])
            begin
                free_idx = slot;
                return -1;
            end
            if (keys[slot] == key) return slot;
            slot = (slot + 1) % ENTRIES;
        end
        return -1;
    endfunction

    task automatic score_item(logic op, logic [KEY_W-1:0] key, int value, logic last);
        int            hit;
        int            free_idx;
        longint        w;
        longint        s;
        score_result_t r;
        hit = find_slot(key, free_idx);
        r = '0;
        if (op == OP_ADD_WEIGHT)
        begin
            r.kind = KIND_ACK;
            if (hit >= 0)
            begin
                w = longint'(weights[hit]) + longint'(value);
                if (w > 64'sh7FFF_FFFF) w = 64'sh7FFF_FFFF;
                if (w < -64'sh8000_0000) w = -64'sh8000_0000;
                weights[hit] = int'(w);
            end
            else if (free_idx >= 0)
            begin
                keys[free_idx] = key;
                weights[free_idx] = value;
                used[free_idx] = 1'b1;
            end
            else
                r.full = 1'b1;
            expected_q.insert(expected_q.size(), r);
            return;
        end
        // Arithmetic shift of the Q32.32 product rounds toward minus infinity.
        if (hit >= 0)
            acc = clamp48(acc + ((longint'(value) * longint'(weights[hit])) >>> 16));
        if (last)
        begin
            s = clamp48(acc - threshold);
            r.kind = KIND_SCORE;
            r.score = s[SCORE_W-1:0];
            r.label = (s > 0);
            expected_q.insert(expected_q.size(), r);
            acc = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        score_result_t got;
        score_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++) used[i] = 1'b0;
            acc = 0;
            threshold = 0;
            errors = 0;
            expected_q.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.kind  = m_axis_tuser;
                got.full  = m_axis_tdata[0];
                got.score = m_axis_tdata[48:1];
                got.label = m_axis_tdata[49];
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.kind !== want.kind || got.full !== want.full ||
                        got.score !== want.score || got.label !== want.label)
                    begin
                        $display("%0t: expected kind %0d full %0d score %h label %0d, got kind %0d full %0d score %h label %0d",
                                 $time, want.kind, want.full, want.score, want.label,
                                 got.kind, got.full, got.score, got.label);
                        errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                score_item(s_axis_tuser, s_axis_tdata[63:0], int'(s_axis_tdata[95:64]),
                           s_axis_tlast);
            if (cfg_we)
                threshold = longint'(signed'(cfg_wdata));
        end
    end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives weight loads and scored feature vectors into the sparse linear
// scorer under varying threshold settings and stream back-pressure.
// ----------------------------------------------------------------------------
module tb;
    import sls_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;
    logic         s_axis_tlast;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [55:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         cfg_we;
    logic [31:0]  cfg_wdata;
    int           errors;
    int           pending;
    int           idle_pct;
    int           stall_pct;
    logic [63:0]  key_pool [32];

    sparse_linear_score i_dut (.*);

    sls_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #8000000;
        $display("sparse_linear_score verification failed");
        $finish;
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0001_0000 * $urandom_range(4);
            3: return -32'sh0001_0000 * $urandom_range(4);
            default: return $urandom();
        endcase
    endfunction

    // Holds one item on the input until it is accepted; the valid stays up
    // into the next item unless the sender idles.
    task automatic send_item(logic op, logic [63:0] key, logic [31:0] value, logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {8'h00, value, key};
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic set_threshold(logic [31:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [63:0] home;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        idle_pct      = 0;
        stall_pct     = 0;
        rst_n         = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme keys, weight saturation both ways, a term on an absent key.
        send_item(OP_ADD_WEIGHT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        send_item(OP_ADD_WEIGHT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_item(OP_ADD_WEIGHT, 64'h0, 32'h8000_0000, 1'b0);
        send_item(OP_ADD_WEIGHT, 64'h0, 32'h8000_0000, 1'b0);
        send_item(OP_TERM, 64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_item(OP_TERM, 64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_item(OP_TERM, 64'h1234, 32'h7FFF_FFFF, 1'b1);
        send_item(OP_TERM, 64'h0, 32'h8000_0000, 1'b0);
        send_item(OP_TERM, 64'h0, 32'h8000_0000, 1'b1);
        send_item(OP_TERM, 64'h0, 32'hFFFF_FFFF, 1'b1);
        // Fill one probe chain past its length so the table reports full.
        for (int i = 0; i < 10; i++)
            send_item(OP_ADD_WEIGHT, 64'h0000_0000_0000_0200 + (64'(i) << 10),
                      32'h0001_0000, 1'b0);
        set_threshold(32'h8000_0000);
        send_item(OP_TERM, 64'h5, 32'h0, 1'b1);
        set_threshold(32'h7FFF_FFFF);
        send_item(OP_TERM, 64'h5, 32'h0, 1'b1);

        for (int i = 0; i < 32; i++)
        begin
            home = {$urandom(), $urandom()};
            // Some keys share a home slot with others to exercise probing.
            key_pool[i] = (i % 4 == 0) ? home : {home[63:10], 10'(i % 3 + 16)};
        end

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 67; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 67; end
                default: begin idle_pct = 25; stall_pct = 25; end
            endcase
            set_threshold(phase == 4 ? 32'h0 : $urandom());
            for (int n = 0; n < 105; n++)
            begin
                if ($urandom_range(3) == 0)
                    send_item(OP_ADD_WEIGHT,
                              $urandom_range(5) == 0 ? {$urandom(), $urandom()}
                                                     : key_pool[$urandom_range(31)],
                              rand_value(), 1'($urandom_range(1)));
                else
                    send_item(OP_TERM,
                              $urandom_range(7) == 0 ? {$urandom(), $urandom()}
                                                     : key_pool[$urandom_range(31)],
                              rand_value(), $urandom_range(4) == 0);
            end
        end

        s_axis_tvalid <= 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("sparse_linear_score verification clean");
        else
            $display("sparse_linear_score verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
design/sls_pkg.sv
design/sls_front.sv
design/sls_back.sv
design/sparse_linear_score.sv
verif/sls_checker.sv
verif/tb.sv
